// File: rtl/core/fba_pkg.sv
// fba_pkg: shared sizes, codes and the scan beat type of the fit block allocator
// used by fba_cell and fit_block_allocator_unit; no dependencies
package fba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  // allocation policy codes
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  // configuration register indexes
  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // input item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // request beat that walks down the cell chain
  typedef struct packed {
    logic                 valid;
    logic [SIZE_BITS-1:0] req;
    logic [1:0]           mode;
    logic [CNT_W-1:0]     active;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] best;
  } fba_scan_t;

endpackage

// File: rtl/core/fit_block_allocator_unit.sv
// fit_block_allocator_unit: first / best / worst fit allocator over a chain of cells
// depends on fba_pkg and fba_cell
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | in_kind, in_slot, in_size
//  out_    | output    | out_valid/out_stall | out_granted, out_block_index
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// a load's result is registered in the cycle after acceptance; a request walks the
// NUM_BLOCKS cells one per cycle, through the scan register of each cell, then its
// result is registered while the granted entry is cleared on the same edge
// one item is in flight at a time; a new item is taken on the edge its result leaves
// synchronous active-low reset empties the table, fit_mode 0, block_count 16
// out_stall holds the result register and, through it, in_stall
module fit_block_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_granted,
  output logic [3:0]  out_block_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);

  localparam int NB = fba_pkg::NUM_BLOCKS;

  logic [1:0]               fit_mode_r;
  logic [4:0]               block_count_r;
  logic                     busy_r;
  logic                     out_valid_r;
  logic                     out_granted_r;
  logic [3:0]               out_block_index_r;
  logic                     in_acc;
  logic                     load_ok;
  logic [fba_pkg::CNT_W-1:0] active;
  fba_pkg::fba_scan_t       head;
  fba_pkg::fba_scan_t       chain [NB+1];
  fba_pkg::fba_scan_t       tail;

  assign in_stall  = busy_r || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign load_ok   = (32'(in_slot) < NB);

  always_comb begin
    if (32'(block_count_r) > NB) begin
      active = fba_pkg::CNT_W'(NB);
    end else begin
      active = fba_pkg::CNT_W'(block_count_r);
    end
  end

  // request beat enters the head cell on the accept edge
  always_comb begin
    head.valid  = in_acc && (in_kind == fba_pkg::KIND_REQUEST);
    head.req    = fba_pkg::SIZE_BITS'(in_size);
    head.mode   = fit_mode_r;
    head.active = active;
    head.found  = 1'b0;
    head.pick   = '0;
    head.best   = '0;
  end

  assign chain[0] = head;
  assign tail     = chain[NB];

  for (genvar g = 0; g < NB; g++) begin : g_cell
    logic ld;
    logic clr;
    assign ld  = in_acc && (in_kind == fba_pkg::KIND_LOAD) && load_ok &&
                 (32'(in_slot) == g);
    assign clr = tail.valid && tail.found && (32'(tail.pick) == g);
    fba_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (fba_pkg::IDX_W'(g)),
      .load_en   (ld),
      .load_data (fba_pkg::SIZE_BITS'(in_size)),
      .clr_en    (clr),
      .scan_i    (chain[g]),
      .scan_o    (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= fba_pkg::MODE_FIRST;
      block_count_r <= 5'd16;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fba_pkg::REG_FIT_MODE:    fit_mode_r    <= cfg_wdata[1:0];
          fba_pkg::REG_BLOCK_COUNT: block_count_r <= cfg_wdata;
          default:                  ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_kind == fba_pkg::KIND_REQUEST) begin
          busy_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end
      if (tail.valid) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end
    end
    if (in_acc && (in_kind == fba_pkg::KIND_LOAD)) begin
      out_granted_r     <= 1'b0;
      out_block_index_r <= 4'd0;
    end else if (tail.valid) begin
      out_granted_r     <= tail.found;
      out_block_index_r <= tail.found ? 4'(tail.pick) : 4'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_block_index = out_block_index_r;

`ifndef SYNTHESIS
  a_tail_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> busy_r)
    else $error("scan beat reached the tail with no request in flight");

  a_tail_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |=> (out_valid_r && !busy_r))
    else $error("finished scan did not raise a result");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !out_valid_r)
    else $error("result pending while a scan is in flight");

  a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_granted_r) |-> (out_block_index_r == 4'd0))
    else $error("nonzero index on a beat without a grant");
`endif

endmodule

// File: rtl/core/fba_cell.sv
// fba_cell: one table entry of the allocator plus its stage of the scan chain
// depends on fba_pkg
module fba_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fba_pkg::IDX_W-1:0]     cell_idx,
  input  logic                          load_en,
  input  logic [fba_pkg::SIZE_BITS-1:0] load_data,
  input  logic                          clr_en,
  input  fba_pkg::fba_scan_t            scan_i,
  output fba_pkg::fba_scan_t            scan_o
);

  logic [fba_pkg::SIZE_BITS-1:0] size_r;
  fba_pkg::fba_scan_t            scan_r;
  fba_pkg::fba_scan_t            scan_nxt;
  logic                          in_range;
  logic                          elig;
  logic                          take;

  always_comb begin
    in_range = fba_pkg::CNT_W'(cell_idx) < scan_i.active;
    elig     = in_range && (size_r != '0) && (size_r >= scan_i.req);
    take     = 1'b0;
    if (elig) begin
      if (!scan_i.found) begin
        take = 1'b1;
      end else begin
        case (scan_i.mode)
          fba_pkg::MODE_BEST:  take = size_r < scan_i.best;
          fba_pkg::MODE_WORST: take = size_r > scan_i.best;
          default:             take = 1'b0;  // first fit keeps the earliest match
        endcase
      end
    end
    scan_nxt = scan_i;
    if (take) begin
      scan_nxt.found = 1'b1;
      scan_nxt.pick  = cell_idx;
      scan_nxt.best  = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r       <= '0;
      scan_r.valid <= 1'b0;
    end else begin
      if (load_en) begin
        size_r <= load_data;
      end else if (clr_en) begin
        size_r <= '0;
      end
      scan_r.valid <= scan_nxt.valid;
    end
    scan_r.req    <= scan_nxt.req;
    scan_r.mode   <= scan_nxt.mode;
    scan_r.active <= scan_nxt.active;
    scan_r.found  <= scan_nxt.found;
    scan_r.pick   <= scan_nxt.pick;
    scan_r.best   <= scan_nxt.best;
  end

  assign scan_o = scan_r;

endmodule
